FILE: hw/rtl/mtg_pkg.sv
`default_nettype none

package mtg_pkg;

  // Pool geometry of the generator.
  localparam int unsigned POOL_LEN  = 624;
  localparam int unsigned TWIST_OFS = 397;
  localparam int unsigned IDX_W     = 10;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(POOL_LEN - 1);
  localparam logic [IDX_W-1:0] OFS_IDX   = IDX_W'(TWIST_OFS);
  localparam logic [IDX_W-1:0] FAR_WRAP  = IDX_W'(POOL_LEN - TWIST_OFS);

  // Recurrence and tempering constants.
  localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;
  localparam logic [31:0] SEED_MUL  = 32'd1812433253;

  // Command opcodes.
  localparam logic [1:0] OP_SEED = 2'd0;
  localparam logic [1:0] OP_WORD = 2'd1;
  localparam logic [1:0] OP_FRAC = 2'd2;
  localparam logic [1:0] OP_NOP  = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] seed_value;
  } mtg_cmd_t;

  typedef struct packed {
    logic [52:0] random_value;
    logic        not_seeded;
  } mtg_result_t;

  // Write request into the state pool.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [31:0]      data;
  } mtg_wr_t;

  // One step of the twist recurrence.
  function automatic logic [31:0] mtg_twist(input logic [31:0] cur,
                                            input logic [31:0] nxt,
                                            input logic [31:0] far);
    logic [31:0] y;
    y = {cur[31], nxt[30:0]};
    return far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
  endfunction

  // Output tempering of a pool word.
  function automatic logic [31:0] mtg_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    return y ^ (y >> 18);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mersenne_twister_generator.sv
`default_nettype none

// MT19937 generator with the 624-word state held in a synchronous memory with
// two read ports. A command is taken when start is high and busy is low; a
// draw gives one result, shown for a single cycle with result_valid, which
// the receiver must take as it comes. Each pool word is twisted when it is
// drawn, so a word draw keeps busy high only for its S_TWIST state and its
// result appears in the cycle after, when a new command can already be taken.
// A fraction draw needs two words and a second memory read, passing through
// S_TWIST, S_READ and S_TWIST again. A draw before any reseed, word or
// fraction, returns zero with not_seeded set straight after S_TWIST. A reseed
// keeps busy high while the seeder fills the pool, with a multiply and an add
// step per word for its registered multiplier. Opcode 3 is taken and ignored.
module mersenne_twister_generator (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire mtg_pkg::mtg_cmd_t     cmd,
  output logic                       result_valid,
  output mtg_pkg::mtg_result_t       result
);
  import mtg_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SEED  = 2'd1;
  localparam logic [1:0] S_TWIST = 2'd2;
  localparam logic [1:0] S_READ  = 2'd3;

  logic [1:0]       state;
  logic             seeded;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] k_inc;
  logic             op_frac;
  logic             second;
  logic [31:0]      cur_word;
  logic [26:0]      frac_hi;

  logic [31:0]      pool [POOL_LEN];
  logic [IDX_W-1:0] ra_next;
  logic [IDX_W-1:0] ra_far;
  logic [31:0]      rd_next;
  logic [31:0]      rd_far;

  mtg_wr_t          seed_wr;
  logic             seed_done;
  logic             seed_go;
  logic             accept;
  logic             twist_we;
  logic [31:0]      new_word;
  logic [31:0]      tempered;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);
  assign seed_go = accept && (cmd.opcode == OP_SEED);

  mtg_seeder u_seeder (
    .clk  (clk),
    .rst  (rst),
    .go   (seed_go),
    .seed (cmd.seed_value),
    .wr   (seed_wr),
    .done (seed_done)
  );

  // Read addresses follow the draw index: its successor and its far partner.
  always_comb begin
    k_inc   = (k == LAST_IDX) ? '0 : k + IDX_W'(1);
    ra_next = k_inc;
    ra_far  = (k < FAR_WRAP) ? k + OFS_IDX : k - FAR_WRAP;
  end

  // Twist of the current word and tempering of the result.
  assign new_word = mtg_twist(cur_word, rd_next, rd_far);
  assign tempered = mtg_temper(new_word);
  assign twist_we = (state == S_TWIST) && seeded;

  // State pool: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (seed_wr.en) begin
      pool[seed_wr.addr] <= seed_wr.data;
    end else if (twist_we) begin
      pool[k] <= new_word;
    end
    rd_next <= pool[ra_next];
    rd_far  <= pool[ra_far];
  end

  // Control sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      seeded       <= 1'b0;
      k            <= '0;
      op_frac      <= 1'b0;
      second       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (cmd.opcode == OP_SEED) begin
              state <= S_SEED;
            end else if (cmd.opcode inside {OP_WORD, OP_FRAC}) begin
              op_frac <= (cmd.opcode == OP_FRAC);
              second  <= 1'b0;
              state   <= S_TWIST;
            end
          end
        end
        S_SEED: begin
          if (seed_done) begin
            state  <= S_IDLE;
            seeded <= 1'b1;
            k      <= '0;
          end
        end
        S_TWIST: begin
          if (!seeded) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            k <= k_inc;
            if (op_frac && !second) begin
              second <= 1'b1;
              state  <= S_READ;
            end else begin
              result_valid <= 1'b1;
              state        <= S_IDLE;
            end
          end
        end
        S_READ: begin
          state <= S_TWIST;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: current pool word, first fraction half and result.
  always_ff @(posedge clk) begin
    if (accept && (cmd.opcode == OP_SEED)) begin
      cur_word <= cmd.seed_value;
    end else if (twist_we) begin
      cur_word <= rd_next;
    end
    if (twist_we && op_frac && !second) begin
      frac_hi <= tempered[31:5];
    end
    if (state == S_TWIST) begin
      if (!seeded) begin
        result.random_value <= '0;
        result.not_seeded   <= 1'b1;
      end else begin
        result.random_value <= op_frac ? {frac_hi, tempered[31:6]} : {21'd0, tempered};
        result.not_seeded   <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mtg_seeder.sv
`default_nettype none

module mtg_seeder (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            go,
  input  wire logic [31:0]     seed,
  output mtg_pkg::mtg_wr_t     wr,
  output logic                 done
);
  import mtg_pkg::*;

  logic             running;
  logic             phase;
  logic [IDX_W-1:0] idx;
  logic [31:0]      s;
  logic [31:0]      prod;
  logic [31:0]      mix;
  logic [31:0]      mul;

  // Knuth recurrence: multiply in phase 0, add the next word's index in phase 1.
  assign mix = s ^ (s >> 30);
  assign mul = mix * SEED_MUL;

  assign wr.en   = running && !phase;
  assign wr.addr = idx;
  assign wr.data = s;
  assign done    = running && phase && (idx == LAST_IDX);

  // Sequencing over the pool, a write-and-multiply phase and an add phase per word.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      phase   <= 1'b0;
      idx     <= '0;
    end else if (go) begin
      running <= 1'b1;
      phase   <= 1'b0;
      idx     <= '0;
    end else if (running) begin
      phase <= !phase;
      if (phase) begin
        if (idx == LAST_IDX) begin
          running <= 1'b0;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

  // Recurrence datapath.
  always_ff @(posedge clk) begin
    if (go) begin
      s <= seed;
    end else if (running) begin
      if (!phase) begin
        prod <= mul;
      end else begin
        s <= prod + 32'(idx) + 32'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mtg_checker.sv
`default_nettype none

module mtg_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire mtg_pkg::mtg_cmd_t     cmd,
  input wire logic                  result_valid,
  input wire mtg_pkg::mtg_result_t  result
);
  import mtg_pkg::*;

  // Every command other than the unused opcode occupies the block.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.opcode != OP_NOP) |=> busy)
    else $error("command accepted without the block going busy");

  // A result always follows a busy cycle.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result shown without preceding work");

  // Results are single-cycle strobes and never come back to back.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("results on consecutive cycles");

  // An unseeded draw carries a zero value.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.not_seeded) |-> (result.random_value == 53'd0))
    else $error("unseeded draw with a non-zero value");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (.*);

`default_nettype wire
